// ===== design/cfe_pkg.sv =====
// Shared types and constants of the COBS frame encoder.
package cfe_pkg;

    localparam int OFS_W       = 11;
    localparam int BYTE_W      = 8;
    localparam int MAX_FRAME   = 1024;
    localparam int CNT_W       = $clog2(MAX_FRAME + 1);
    localparam int MAX_WR      = 3;
    localparam int WR_CNT_W    = $clog2(MAX_WR + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] FULL_CODE  = 8'hFF;
    localparam logic [BYTE_W-1:0] FIRST_CODE = 8'h01;
    localparam logic [OFS_W-1:0]  FIRST_OFS  = 11'd1;

    typedef struct packed {
        logic [OFS_W-1:0]  offset;
        logic [BYTE_W-1:0] value;
        logic              last;
        logic [OFS_W-1:0]  length;
        logic              overflow;
    } t_wr;

    typedef struct packed {
        t_wr [MAX_WR-1:0]    wr;
        logic [WR_CNT_W-1:0] cnt;
    } t_job;

endpackage

// ===== design/cfe_front.sv =====
// Front end: accepts source bytes, tracks frame state and builds the write list of each byte.
module cfe_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [cfe_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                      i_end_of_frame,
    output cfe_pkg::t_job             o_job,
    output logic                      o_has_writes
);

    logic [cfe_pkg::OFS_W-1:0]  r_no, n_no;
    logic [cfe_pkg::OFS_W-1:0]  r_gco, n_gco;
    logic [cfe_pkg::BYTE_W-1:0] r_gc, n_gc;
    logic [cfe_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_ovf, n_ovf;

    cfe_pkg::t_wr               w_final;
    cfe_pkg::t_job              w_job;
    logic [cfe_pkg::OFS_W-1:0]  w_no_a;
    logic [cfe_pkg::BYTE_W-1:0] w_gc_a;

    always_comb begin
        w_job   = '0;
        w_final = '0;
        n_ovf   = r_ovf | (r_cnt >= cfe_pkg::CNT_W'(cfe_pkg::MAX_FRAME));
        n_no    = r_no;
        n_gco   = r_gco;
        n_gc    = r_gc;
        n_cnt   = r_cnt;
        w_no_a  = r_no + 1'b1;
        w_gc_a  = r_gc + 1'b1;
        if (!n_ovf) begin
            n_cnt = r_cnt + 1'b1;
            if (i_data_byte == '0) begin
                w_job.wr[0].offset = r_gco;
                w_job.wr[0].value  = r_gc;
                w_job.cnt          = cfe_pkg::WR_CNT_W'(1);
                n_gco              = r_no;
                n_no               = w_no_a;
                n_gc               = cfe_pkg::FIRST_CODE;
            end else begin
                w_job.wr[0].offset = r_no;
                w_job.wr[0].value  = i_data_byte;
                w_job.cnt          = cfe_pkg::WR_CNT_W'(1);
                if (w_gc_a == cfe_pkg::FULL_CODE) begin
                    w_job.wr[1].offset = r_gco;
                    w_job.wr[1].value  = cfe_pkg::FULL_CODE;
                    w_job.cnt          = cfe_pkg::WR_CNT_W'(2);
                    n_gco              = w_no_a;
                    n_no               = w_no_a + 1'b1;
                    n_gc               = cfe_pkg::FIRST_CODE;
                end else begin
                    n_no = w_no_a;
                    n_gc = w_gc_a;
                end
            end
            w_final.offset = n_gco;
            w_final.value  = n_gc;
            w_final.last   = 1'b1;
            w_final.length = n_no;
        end else begin
            w_final.last     = 1'b1;
            w_final.overflow = 1'b1;
        end
        if (i_end_of_frame) begin
            case (w_job.cnt)
                cfe_pkg::WR_CNT_W'(0): w_job.wr[0] = w_final;
                cfe_pkg::WR_CNT_W'(1): w_job.wr[1] = w_final;
                default:               w_job.wr[2] = w_final;
            endcase
            w_job.cnt = w_job.cnt + 1'b1;
            n_no      = cfe_pkg::FIRST_OFS;
            n_gco     = '0;
            n_gc      = cfe_pkg::FIRST_CODE;
            n_cnt     = '0;
            n_ovf     = 1'b0;
        end
    end

    assign o_job        = w_job;
    assign o_has_writes = (w_job.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no  <= cfe_pkg::FIRST_OFS;
            r_gco <= '0;
            r_gc  <= cfe_pkg::FIRST_CODE;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_accept) begin
            r_no  <= n_no;
            r_gco <= n_gco;
            r_gc  <= n_gc;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_end_of_frame |=> r_no == cfe_pkg::FIRST_OFS && r_gco == '0
            && r_gc == cfe_pkg::FIRST_CODE && !r_ovf)
        else $error("frame state not cleared after end of frame");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= cfe_pkg::CNT_W'(cfe_pkg::MAX_FRAME))
        else $error("source count ran past the frame limit");

endmodule

// ===== design/cfe_queue.sv =====
// Short queue of write lists between the front and back ends.
module cfe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfe_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cfe_pkg::t_job o_job
);

    cfe_pkg::t_job               r_mem [cfe_pkg::QUEUE_DEPTH];
    logic [cfe_pkg::QPTR_W-1:0]  r_wp;
    logic [cfe_pkg::QPTR_W-1:0]  r_rp;
    logic [cfe_pkg::QCNT_W-1:0]  r_count;
    logic                        w_push;
    logic                        w_pop;

    assign o_full  = (r_count == cfe_pkg::QCNT_W'(cfe_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cfe_pkg::QCNT_W'(cfe_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== design/cfe_back.sv =====
// Back end: plays out the writes of each queued list one per cycle while i_pop is high.
module cfe_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cfe_pkg::t_job              i_job,
    input  logic                       i_q_empty,
    output logic                       o_q_pop,
    output logic                       o_empty,
    input  logic                       i_pop,
    output cfe_pkg::t_wr               o_wr
);

    cfe_pkg::t_job                 r_job;
    logic [cfe_pkg::WR_CNT_W-1:0]  r_idx;
    logic                          r_valid;
    logic                          w_take;
    logic                          w_done;

    assign w_take  = i_pop && r_valid;
    assign w_done  = w_take && (r_idx == r_job.cnt - 1'b1);
    assign o_q_pop = (!r_valid || w_done) && !i_q_empty;
    assign o_empty = !r_valid;
    assign o_wr    = r_job.wr[r_idx[cfe_pkg::WR_CNT_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_done) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_take) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx < r_job.cnt)
        else $error("write index beyond the list");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && o_wr.last |-> r_idx == r_job.cnt - 1'b1)
        else $error("final write is not the last of its list");

endmodule

// ===== design/cobs_frame_encoder_core.sv =====
// Top level of the COBS frame encoder: front end, write-list queue and back end.
//
//   Channel  Handshake          Payload
//   input    push / full        i_data_byte, i_end_of_frame
//   result   empty / pop        o_write_offset, o_byte_value, o_last_write,
//                               o_encoded_length, o_overflow
//
// One source byte is accepted per cycle while the queue has room.
// The back end gives one write per cycle while pop is high, so a byte causing k writes holds it until all are taken.
// A result reaches the ports once its write list has passed the queue and been loaded into the back end register.
// The queue holds the write lists of four bytes and the back end holds one more.
// Reset returns the frame state to its start and empties the queue and result stage.
// A stalled result side fills the queue, after which full is raised.
module cobs_frame_encoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [cfe_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_end_of_frame,
    output logic                        empty,
    input  logic                        pop,
    output logic [cfe_pkg::OFS_W-1:0]   o_write_offset,
    output logic [cfe_pkg::BYTE_W-1:0]  o_byte_value,
    output logic                        o_last_write,
    output logic [cfe_pkg::OFS_W-1:0]   o_encoded_length,
    output logic                        o_overflow
);

    cfe_pkg::t_job w_front_job;
    cfe_pkg::t_job w_head_job;
    cfe_pkg::t_wr  w_wr;
    logic          w_accept;
    logic          w_has_writes;
    logic          w_q_empty;
    logic          w_q_pop;

    assign w_accept = push && !full;

    cfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_data_byte    (i_data_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_job          (w_front_job),
        .o_has_writes   (w_has_writes)
    );

    cfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && w_has_writes),
        .i_job   (w_front_job),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_job   (w_head_job)
    );

    cfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (w_head_job),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_wr      (w_wr)
    );

    assign o_write_offset   = w_wr.offset;
    assign o_byte_value     = w_wr.value;
    assign o_last_write     = w_wr.last;
    assign o_encoded_length = w_wr.length;
    assign o_overflow       = w_wr.overflow;

endmodule

// ===== sim/cobs_write_checker.sv =====
// Write-stream checker for the COBS frame encoder: predicts every buffer write and compares it.
module cobs_write_checker
    import cfe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_end_of_frame,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic [OFS_W-1:0]  i_write_offset,
    input  logic [BYTE_W-1:0] i_byte_value,
    input  logic              i_last_write,
    input  logic [OFS_W-1:0]  i_encoded_length,
    input  logic              i_overflow,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    t_wr               expected_writes[$];
    logic [OFS_W-1:0]  next_ofs;
    logic [OFS_W-1:0]  code_ofs;
    logic [BYTE_W-1:0] group_code;
    int                src_count;
    logic              ovf_seen;
    int                fails;
    int                checked;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        fails        = 0;
        checked      = 0;
    end

    function automatic t_wr make_write(input logic [OFS_W-1:0] ofs, input logic [BYTE_W-1:0] val,
                                       input logic last, input logic [OFS_W-1:0] len,
                                       input logic ovf);
        t_wr w;
        w.offset   = ofs;
        w.value    = val;
        w.last     = last;
        w.length   = len;
        w.overflow = ovf;
        return w;
    endfunction

    task automatic restart_frame();
        next_ofs   = FIRST_OFS;
        code_ofs   = '0;
        group_code = FIRST_CODE;
        src_count  = 0;
        ovf_seen   = 1'b0;
    endtask

    task automatic close_group();
        expected_writes.push_back(make_write(code_ofs, group_code, 1'b0, '0, 1'b0));
        code_ofs   = next_ofs;
        next_ofs   = next_ofs + 1'b1;
        group_code = FIRST_CODE;
    endtask

    task automatic predict_writes(input logic [BYTE_W-1:0] b, input logic eof);
        if (!ovf_seen && src_count >= MAX_FRAME) begin
            ovf_seen = 1'b1;
        end
        if (!ovf_seen) begin
            src_count++;
            if (b == 8'h00) begin
                close_group();
            end else begin
                expected_writes.push_back(make_write(next_ofs, b, 1'b0, '0, 1'b0));
                next_ofs   = next_ofs + 1'b1;
                group_code = group_code + 1'b1;
                if (group_code == FULL_CODE) begin
                    close_group();
                end
            end
        end
        if (eof) begin
            if (ovf_seen) begin
                expected_writes.push_back(make_write('0, '0, 1'b1, '0, 1'b1));
            end else begin
                expected_writes.push_back(make_write(code_ofs, group_code, 1'b1, next_ofs, 1'b0));
            end
            restart_frame();
        end
    endtask

    task automatic check_write();
        t_wr want;
        if (expected_writes.size() == 0) begin
            $error("write transfer with none expected: offset %0d, value %0d",
                   i_write_offset, i_byte_value);
            fails++;
            return;
        end
        want = expected_writes.pop_front();
        checked++;
        if (i_write_offset !== want.offset) begin
            $error("write_offset: expected %0d, actual %0d", want.offset, i_write_offset);
            fails++;
        end
        if (i_byte_value !== want.value) begin
            $error("byte_value: expected %0d, actual %0d", want.value, i_byte_value);
            fails++;
        end
        if (i_last_write !== want.last) begin
            $error("last_write: expected %0d, actual %0d", want.last, i_last_write);
            fails++;
        end
        if (i_encoded_length !== want.length) begin
            $error("encoded_length: expected %0d, actual %0d", want.length, i_encoded_length);
            fails++;
        end
        if (i_overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, i_overflow);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_frame();
            expected_writes.delete();
        end else begin
            if (i_pop && !i_empty) begin
                check_write();
            end
            if (i_push && !i_full) begin
                predict_writes(i_data_byte, i_end_of_frame);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_writes.size();
        o_checked    <= checked;
    end

endmodule

// ===== sim/tb_top.sv =====
// Top of the COBS frame encoder testbench: clock, reset, source and sink traffic, and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cfe_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 8;
    localparam int IDLE_PCT     = 11;
    localparam int QUIET_FROM   = 100;
    localparam int QUIET_TO     = 250;
    localparam int HOLD_AT      = 280;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [BYTE_W-1:0] i_data_byte;
    logic              i_end_of_frame;
    logic              empty;
    logic              pop;
    logic [OFS_W-1:0]  o_write_offset;
    logic [BYTE_W-1:0] o_byte_value;
    logic              o_last_write;
    logic [OFS_W-1:0]  o_encoded_length;
    logic              o_overflow;

    int   cyc = 0;
    int   frames_sent = 0;
    int   bytes_sent = 0;
    int   fail_count;
    int   pending;
    int   checked;
    logic quiet;

    assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    cobs_frame_encoder_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_end_of_frame   (i_end_of_frame),
        .empty            (empty),
        .pop              (pop),
        .o_write_offset   (o_write_offset),
        .o_byte_value     (o_byte_value),
        .o_last_write     (o_last_write),
        .o_encoded_length (o_encoded_length),
        .o_overflow       (o_overflow)
    );

    cobs_write_checker u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_data_byte      (i_data_byte),
        .i_end_of_frame   (i_end_of_frame),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_write_offset   (o_write_offset),
        .i_byte_value     (o_byte_value),
        .i_last_write     (o_last_write),
        .i_encoded_length (o_encoded_length),
        .i_overflow       (o_overflow),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eof);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_data_byte    <= b;
        i_end_of_frame <= eof;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        bytes_sent++;
        if (eof) begin
            frames_sent++;
        end
    endtask

    task automatic send_frame(input int len, input int zero_pct);
        logic [BYTE_W-1:0] b;
        for (int k = 0; k < len; k++) begin
            b = ($urandom_range(99) < zero_pct) ? 8'h00 : BYTE_W'($urandom_range(255, 1));
            send_byte(b, k == len - 1);
        end
    endtask

    initial begin : result_side
        bit held;
        held = 1'b0;
        pop  = 1'b0;
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            if (!held && cyc >= HOLD_AT) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else begin
                pop <= quiet || ($urandom_range(99) >= IDLE_PCT);
                @(posedge i_clk);
            end
        end
    end

    initial begin : source_side
        int random_from;
        int pick;
        int len;
        int zero_pct;
        int left;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_data_byte    = '0;
        i_end_of_frame = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);

        // A full group closing on the last byte of its frame.
        send_frame(254, 0);

        random_from = bytes_sent;
        while (bytes_sent - random_from < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len      = $urandom_range(16, 1);
                zero_pct = 25;
            end else if (pick < 90) begin
                len      = $urandom_range(64, 17);
                zero_pct = 5;
            end else if (pick < 96) begin
                len      = $urandom_range(300, 240);
                zero_pct = 0;
            end else begin
                len      = $urandom_range(8, 1);
                zero_pct = 90;
            end
            left = RANDOM_ITEMS - (bytes_sent - random_from);
            if (len > left) begin
                len = left;
            end
            send_frame(len, zero_pct);
        end
        push <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d frames, %0d source bytes and %0d checked writes,",
                 frames_sent, bytes_sent, checked);
        $display("including zero runs, a full group at frame end and a stalled result side.");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
